/* hw/rtl/md5sh_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// md5sh_pkg
// Types, constants and round tables shared by the MD5 stream hasher.
// ---------------------------------------------------------------------------
package md5sh_pkg;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] message_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_low;
    logic [63:0] digest_high;
  } out_item_t;

  // block kinds: plain data, first padded block, length-only block
  localparam logic [1:0] MODE_DATA  = 2'd0;
  localparam logic [1:0] MODE_PAD_A = 2'd1;
  localparam logic [1:0] MODE_PAD_B = 2'd2;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'h3f;

  typedef struct packed {
    logic       load_byte;
    logic       fetch;
    logic [5:0] rnd;
    logic       start;
    logic       step;
    logic       fold;
    logic       finish;
    logic [1:0] mode;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pos_high;
    logic pos_wrap;
    logic out_busy;
  } dp_status_t;

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] r4;
    logic [3:0] idx;
    r4 = r[3:0];
    case (r[5:4])
      2'd0:    idx = r4;
      2'd1:    idx = r4 * 4'd5 + 4'd1;
      2'd2:    idx = r4 * 4'd3 + 4'd5;
      default: idx = r4 * 4'd7;
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
      4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] sine_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/md5_stream_hasher.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// md5_stream_hasher
// MD5 digest of a byte stream: one byte per item, padding and length
// appended on the last-of-message mark, 16-byte digest per message.
// ---------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------
//  in      | in_valid/in_stall  | has_byte, message_byte, is_last
//  out     | out_valid/out_stall| digest_low, digest_high (one per message)
//
//  A byte that does not complete a block is taken without a stall.
//  Each block runs a word prefetch, 64 rounds and a chaining add on
//  the single shared round unit; closing a message takes one or
//  two blocks. Input is stalled while a block compresses.
//  After reset the block is ready at once, with the MD5 initial words.
//  A stalled digest sits in the output register; bytes of the next message
//  keep flowing, and only its closing waits until that digest is taken.
// ---------------------------------------------------------------------------
module md5_stream_hasher (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  md5sh_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output md5sh_pkg::out_item_t out_item
);

  md5sh_pkg::ctrl_cmd_t  cmd;
  md5sh_pkg::dp_status_t sts;

  md5sh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  md5sh_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (in_item),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

/* hw/rtl/md5sh_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// md5sh_ctrl
// Sequencer: takes input items, runs the 64 rounds of each block and
// decides on padding blocks and digest delivery.
// ---------------------------------------------------------------------------
module md5sh_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  input  md5sh_pkg::in_item_t   in_item,
  output logic                  in_stall,
  input  md5sh_pkg::dp_status_t sts,
  output md5sh_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_ROUND = 2'd2;
  localparam logic [1:0] ST_WRAP  = 2'd3;

  logic [1:0] state, state_next;
  logic [5:0] cnt, cnt_next;
  logic [1:0] mode, mode_next;
  logic       pending_last, pending_last_next;
  logic       final_blk;

  assign in_stall  = (state != ST_IDLE);
  assign final_blk = (mode == md5sh_pkg::MODE_PAD_B) ||
                     ((mode == md5sh_pkg::MODE_PAD_A) && !sts.pos_high);

  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    mode_next         = mode;
    pending_last_next = pending_last;
    cmd               = '0;
    cmd.mode          = mode;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_byte = in_item.has_byte;
          if (in_item.has_byte && sts.pos_wrap) begin
            mode_next         = md5sh_pkg::MODE_DATA;
            pending_last_next = in_item.is_last;
            state_next        = ST_FETCH;
          end else if (in_item.is_last) begin
            mode_next  = md5sh_pkg::MODE_PAD_A;
            state_next = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        cmd.rnd    = 6'd0;
        cmd.start  = 1'b1;
        cnt_next   = 6'd0;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.step = 1'b1;
        if (cnt != md5sh_pkg::LAST_POS) begin
          cmd.fetch = 1'b1;
          cmd.rnd   = cnt + 6'd1;
          cnt_next  = cnt + 6'd1;
        end else begin
          state_next = ST_WRAP;
        end
      end
      ST_WRAP: begin
        if (final_blk) begin
          // hold the working words until the output register frees up
          if (!sts.out_busy) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.fold = 1'b1;
          if (mode == md5sh_pkg::MODE_DATA && pending_last) begin
            pending_last_next = 1'b0;
            mode_next         = md5sh_pkg::MODE_PAD_A;
            state_next        = ST_FETCH;
          end else if (mode == md5sh_pkg::MODE_PAD_A) begin
            mode_next  = md5sh_pkg::MODE_PAD_B;
            state_next = ST_FETCH;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= 6'd0;
      mode         <= md5sh_pkg::MODE_DATA;
      pending_last <= 1'b0;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      mode         <= mode_next;
      pending_last <= pending_last_next;
    end
  end

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !sts.out_busy)
    else $error("digest loaded while output register busy");

  a_wrap_after_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRAP && $past(state) != ST_WRAP)
      |-> $past(state) == ST_ROUND && $past(cnt) == md5sh_pkg::LAST_POS)
    else $error("block closed before all rounds ran");

  a_full_block_starts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && in_item.has_byte && sts.pos_wrap)
      |=> state == ST_FETCH && mode == md5sh_pkg::MODE_DATA)
    else $error("full block did not start compression");

endmodule
`default_nettype wire

/* hw/rtl/md5sh_dpath.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// md5sh_dpath
// Block buffer, length counter, round unit, chaining words and the
// digest output register.
// ---------------------------------------------------------------------------
module md5sh_dpath (
  input  wire                   clk,
  input  wire                   rst,
  input  md5sh_pkg::ctrl_cmd_t  cmd,
  input  md5sh_pkg::in_item_t   in_item,
  output md5sh_pkg::dp_status_t sts,
  output logic                  out_valid,
  input  wire                   out_stall,
  output md5sh_pkg::out_item_t  out_item
);

  logic [31:0] words [16];
  logic [5:0]  pos;
  logic [63:0] bit_count;
  logic [31:0] ca, cb, cc, cd;
  logic [31:0] a, b, c, d;
  logic [31:0] wk;
  logic [5:0]  rnd_q;

  logic [3:0]  fidx;
  logic [31:0] raw_word;
  logic [31:0] msg_word;
  logic [31:0] f_val;
  logic [31:0] t_val;
  logic [63:0] rot_dbl;
  logic [31:0] sum_a, sum_b, sum_c, sum_d;

  // byte j of the block as the compression sees it, padding laid over the buffer
  function automatic logic [7:0] blk_byte(input logic [1:0] m, input logic [5:0] j,
                                          input logic [7:0] bv, input logic [5:0] p,
                                          input logic [63:0] len);
    logic [7:0] r;
    logic [7:0] lb;
    lb = len[{j[2:0], 3'b000} +: 8];
    case (m)
      md5sh_pkg::MODE_DATA: r = bv;
      md5sh_pkg::MODE_PAD_A: begin
        if (j < p)                                    r = bv;
        else if (j == p)                              r = md5sh_pkg::PAD_MARK;
        else if (j >= md5sh_pkg::LEN_POS && p < md5sh_pkg::LEN_POS) r = lb;
        else                                          r = 8'h00;
      end
      md5sh_pkg::MODE_PAD_B: r = (j >= md5sh_pkg::LEN_POS) ? lb : 8'h00;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  always_comb begin
    fidx     = md5sh_pkg::msg_index(cmd.rnd);
    raw_word = words[fidx];
    for (int k = 0; k < 4; k++) begin
      msg_word[8*k +: 8] = blk_byte(cmd.mode, {fidx, 2'(k)}, raw_word[8*k +: 8],
                                    pos, bit_count);
    end
  end

  always_comb begin
    case (rnd_q[5:4])
      2'd0:    f_val = (b & c) | (~b & d);
      2'd1:    f_val = (d & b) | (~d & c);
      2'd2:    f_val = b ^ c ^ d;
      default: f_val = c ^ (b | ~d);
    endcase
    t_val   = f_val + a + wk;
    rot_dbl = {t_val, t_val} << md5sh_pkg::rot_amount(rnd_q);
  end

  assign sum_a = ca + a;
  assign sum_b = cb + b;
  assign sum_c = cc + c;
  assign sum_d = cd + d;

  assign sts.pos_high = (pos >= md5sh_pkg::LEN_POS);
  assign sts.pos_wrap = (pos == md5sh_pkg::LAST_POS);
  assign sts.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      words[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= in_item.message_byte;
    end
  end

  // round unit: word + constant fetched one round ahead
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      wk    <= msg_word + md5sh_pkg::sine_k(cmd.rnd);
      rnd_q <= cmd.rnd;
    end
    if (cmd.start) begin
      a <= ca;
      b <= cb;
      c <= cc;
      d <= cd;
    end else if (cmd.step) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b + rot_dbl[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item.digest_low  <= {sum_b, sum_a};
      out_item.digest_high <= {sum_d, sum_c};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 6'd0;
      bit_count <= 64'd0;
      ca        <= md5sh_pkg::INIT_A;
      cb        <= md5sh_pkg::INIT_B;
      cc        <= md5sh_pkg::INIT_C;
      cd        <= md5sh_pkg::INIT_D;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_byte) begin
        pos       <= pos + 6'd1;
        bit_count <= bit_count + 64'd8;
      end
      if (cmd.fold) begin
        ca <= sum_a;
        cb <= sum_b;
        cc <= sum_c;
        cd <= sum_d;
      end
      if (cmd.finish) begin
        ca        <= md5sh_pkg::INIT_A;
        cb        <= md5sh_pkg::INIT_B;
        cc        <= md5sh_pkg::INIT_C;
        cd        <= md5sh_pkg::INIT_D;
        pos       <= 6'd0;
        bit_count <= 64'd0;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("digest valid without a finished message");

  a_restart_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> pos == 6'd0 && bit_count == 64'd0 && ca == md5sh_pkg::INIT_A)
    else $error("message state not restarted after digest");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled digest changed or dropped");

endmodule
`default_nettype wire
